// File: hdl/rad_pkg.sv
// Package for the reference activity detector: field widths, register
// indexes, reset values, mode and controller state types, command structs.
// No dependencies.
package rad_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int PEAK_W     = 15;
    localparam int STREAK_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int MODE_W     = 2;
    localparam int THR_W      = 15;
    localparam int HOLD_W     = 16;
    localparam int WLEN_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Ratio divider: one quotient bit per step
    localparam int Q15_W      = 15;
    localparam int DIV_CNT_W  = 4;

    // Default window capacity
    localparam int WINDOW_MAX_DEFAULT = 16;

    localparam logic [PEAK_W-1:0]   Q15_ONE    = 15'h7FFF;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [THR_W-1:0]  ENTER_THRESHOLD_RST = 15'd128;
    localparam logic [THR_W-1:0]  EXIT_THRESHOLD_RST  = 15'd64;
    localparam logic [HOLD_W-1:0] STABLE_COUNT_RST    = 16'd3;
    localparam logic [HOLD_W-1:0] HANGOVER_COUNT_RST  = 16'd8;
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST   = 5'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_MISSING = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_ACTIVE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_sample;
        logic update;
        logic div_start;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } status_t;

    // One result word
    typedef struct packed {
        logic [MODE_W-1:0]   ref_mode;
        logic [PEAK_W-1:0]   frame_peak;
        logic [STREAK_W-1:0] above_streak;
        logic [STREAK_W-1:0] below_streak;
        logic [STREAK_W-1:0] zero_streak;
        logic [Q15_W-1:0]    active_ratio_q15;
        logic [COUNT_W-1:0]  frames_seen;
        logic [COUNT_W-1:0]  entered_active_count;
        logic [COUNT_W-1:0]  exited_active_count;
    } result_t;

endpackage

// File: hdl/rad_if.sv
// Channel interfaces of the reference activity detector: sample input,
// result output and register write. Depends on rad_pkg.

interface rad_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [rad_pkg::SAMPLE_W-1:0] ref_sample;
    logic                                frame_end;

    modport source (output valid, ref_sample, frame_end, input ready);
    modport sink   (input valid, ref_sample, frame_end, output ready);
endinterface

interface rad_result_if;
    logic                           valid;
    logic                           ready;
    logic [rad_pkg::MODE_W-1:0]     ref_mode;
    logic [rad_pkg::PEAK_W-1:0]     frame_peak;
    logic [rad_pkg::STREAK_W-1:0]   above_streak;
    logic [rad_pkg::STREAK_W-1:0]   below_streak;
    logic [rad_pkg::STREAK_W-1:0]   zero_streak;
    logic [rad_pkg::Q15_W-1:0]      active_ratio_q15;
    logic [rad_pkg::COUNT_W-1:0]    frames_seen;
    logic [rad_pkg::COUNT_W-1:0]    entered_active_count;
    logic [rad_pkg::COUNT_W-1:0]    exited_active_count;

    modport source (output valid, ref_mode, frame_peak, above_streak, below_streak,
                    zero_streak, active_ratio_q15, frames_seen, entered_active_count,
                    exited_active_count, input ready);
    modport sink   (input valid, ref_mode, frame_peak, above_streak, below_streak,
                    zero_streak, active_ratio_q15, frames_seen, entered_active_count,
                    exited_active_count, output ready);
endinterface

interface rad_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rad_pkg::CFG_IDX_W-1:0]     index;
    logic [rad_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/rad_divider.sv
// Bit-serial restoring divider for the activity ratio:
// quotient = active * 32767 / fill, one quotient bit per cycle. Depends on rad_pkg.
module rad_divider #(
    parameter int FW = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [FW-1:0]             active,
    input  logic [FW-1:0]             fill,
    output logic                      done,
    output logic [rad_pkg::Q15_W-1:0] quotient
);

    localparam int QW = rad_pkg::Q15_W;
    localparam int NW = FW + QW;
    localparam logic [rad_pkg::DIV_CNT_W-1:0] LAST_STEP = rad_pkg::DIV_CNT_W'(QW - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rad_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FW-1:0]                  rem_reg, rem_next;
    logic [QW-1:0]                  low_reg, low_next;

    logic [NW-1:0] numer;
    logic [FW:0]   trial;
    logic [FW:0]   diff;
    logic          fits;

    // Numerator is active * 32767; its upper part is already below the divisor
    assign numer = {active, QW'(0)} - NW'(active);

    // One restoring step
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, fill};
    assign fits  = (trial >= {1'b0, fill});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = numer[NW-1:QW];
            low_next  = numer[QW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[FW-1:0] : trial[FW-1:0];
            low_next = {low_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// File: hdl/rad_ctrl.sv
// Controller of the reference activity detector: sequences sample intake,
// frame update, ratio division and the result register. Depends on rad_pkg.
module rad_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_frame_end,
    input  logic             out_ready,
    input  rad_pkg::status_t status,
    output rad_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);

    rad_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_sample = 1'b1;
                    if (in_frame_end)
                    begin
                        state_next = rad_pkg::ST_UPDATE;
                    end
                end
            end
            rad_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = rad_pkg::ST_DIV_START;
            end
            rad_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = rad_pkg::ST_DIV_WAIT;
            end
            rad_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rad_pkg::ST_DONE;
                end
            end
            rad_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rad_pkg::ST_IDLE;
            end
        endcase

        // Hold the result until taken
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hdl/rad_datapath.sv
// Datapath of the reference activity detector: registers, peak tracking,
// streaks, mode update, activity window memory and ratio divider.
// Depends on rad_pkg and rad_divider.
module rad_datapath #(
    parameter int WINDOW_MAX = rad_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rad_pkg::cmd_t                       cmd,
    output rad_pkg::status_t                    status,
    input  logic signed [rad_pkg::SAMPLE_W-1:0] ref_sample,
    input  logic                                frame_end,
    input  logic                                cfg_write,
    input  logic [rad_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rad_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rad_pkg::result_t                    result
);

    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = (FW > rad_pkg::WLEN_W) ? FW : rad_pkg::WLEN_W;
    localparam logic [LW-1:0] WMAX_L = LW'(WINDOW_MAX);

    localparam int PEAK_W   = rad_pkg::PEAK_W;
    localparam int STREAK_W = rad_pkg::STREAK_W;
    localparam int COUNT_W  = rad_pkg::COUNT_W;
    localparam int THR_W    = rad_pkg::THR_W;
    localparam int HOLD_W   = rad_pkg::HOLD_W;

    // Configuration registers
    logic [THR_W-1:0]          enter_thr_reg, enter_thr_next;
    logic [THR_W-1:0]          exit_thr_reg, exit_thr_next;
    logic [HOLD_W-1:0]         stable_reg, stable_next;
    logic [HOLD_W-1:0]         hang_reg, hang_next;
    logic [rad_pkg::WLEN_W-1:0] win_len_reg, win_len_next;

    // Activity state
    rad_pkg::mode_t            mode_reg, mode_next;
    logic [PEAK_W-1:0]         acc_reg, acc_next;
    logic [STREAK_W-1:0]       above_reg, above_next;
    logic [STREAK_W-1:0]       below_reg, below_next;
    logic [STREAK_W-1:0]       zero_reg, zero_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [FW-1:0]             active_reg, active_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [COUNT_W-1:0]        seen_reg, seen_next;
    logic [COUNT_W-1:0]        entered_reg, entered_next;
    logic [COUNT_W-1:0]        exited_reg, exited_next;

    logic [PEAK_W-1:0]         frame_peak_reg;
    logic                      flag_rd_reg;
    logic                      flag_mem [WINDOW_MAX];
    rad_pkg::result_t          result_reg;

    logic [PEAK_W-1:0]         mag;
    logic [PEAK_W-1:0]         peak_cur;
    logic [THR_W-1:0]          en_thr;
    logic [HOLD_W-1:0]         st_cnt;
    logic [HOLD_W-1:0]         hg_cnt;
    logic [LW-1:0]             len_ext;
    logic [FW-1:0]             w_eff;
    logic [PW-1:0]             pos_eff;
    logic [FW-1:0]             pos_inc;
    logic                      win_full;
    logic                      flag;
    logic [FW-1:0]             active_dec;
    logic [STREAK_W-1:0]       zero_upd, above_upd, below_upd;
    logic                      div_done;
    logic [rad_pkg::Q15_W-1:0] quotient;

    function automatic logic [STREAK_W-1:0] sat_inc(input logic [STREAK_W-1:0] v);
        return (v == rad_pkg::STREAK_MAX) ? v : v + 1'b1;
    endfunction

    // Saturated magnitude of the incoming sample
    always_comb
    begin
        if (!ref_sample[rad_pkg::SAMPLE_W-1])
        begin
            mag = ref_sample[PEAK_W-1:0];
        end
        else if (ref_sample[PEAK_W-1:0] == '0)
        begin
            mag = rad_pkg::Q15_ONE;
        end
        else
        begin
            mag = PEAK_W'(~ref_sample + 1'b1);
        end
    end

    assign peak_cur = (mag > acc_reg) ? mag : acc_reg;

    // Effective thresholds and counts
    assign en_thr = (enter_thr_reg < exit_thr_reg) ? exit_thr_reg : enter_thr_reg;
    assign st_cnt = (stable_reg == '0) ? HOLD_W'(1) : stable_reg;
    assign hg_cnt = (hang_reg == '0) ? HOLD_W'(1) : hang_reg;

    // Effective window length and write position
    assign len_ext  = LW'(win_len_reg);
    assign w_eff    = (len_ext == '0) ? FW'(1) :
                      (len_ext > WMAX_L) ? FW'(WMAX_L) : FW'(len_ext);
    assign pos_eff  = (FW'(pos_reg) >= w_eff) ? '0 : pos_reg;
    assign pos_inc  = FW'(pos_eff) + 1'b1;
    assign win_full = (fill_reg >= w_eff);

    // Frame flag and streak candidates
    assign flag       = (frame_peak_reg >= exit_thr_reg);
    assign active_dec = win_full ? active_reg - FW'(flag_rd_reg) : active_reg;
    assign zero_upd   = (frame_peak_reg == '0) ? sat_inc(zero_reg) : '0;
    assign above_upd  = (frame_peak_reg >= en_thr) ? sat_inc(above_reg) : '0;
    assign below_upd  = (frame_peak_reg < exit_thr_reg) ? sat_inc(below_reg) : '0;

    // Next state of registers and activity state
    always_comb
    begin
        enter_thr_next = enter_thr_reg;
        exit_thr_next  = exit_thr_reg;
        stable_next    = stable_reg;
        hang_next      = hang_reg;
        win_len_next   = win_len_reg;
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        above_next     = above_reg;
        below_next     = below_reg;
        zero_next      = zero_reg;
        fill_next      = fill_reg;
        active_next    = active_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        entered_next   = entered_reg;
        exited_next    = exited_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                rad_pkg::REG_ENTER_THRESHOLD: enter_thr_next = cfg_data[THR_W-1:0];
                rad_pkg::REG_EXIT_THRESHOLD:  exit_thr_next  = cfg_data[THR_W-1:0];
                rad_pkg::REG_STABLE_COUNT:    stable_next    = cfg_data[HOLD_W-1:0];
                rad_pkg::REG_HANGOVER_COUNT:  hang_next      = cfg_data[HOLD_W-1:0];
                rad_pkg::REG_WINDOW_LENGTH:   win_len_next   = cfg_data[rad_pkg::WLEN_W-1:0];
                default:                      ;
            endcase
            // Drop activity state on any valid register write
            if (cfg_index <= rad_pkg::REG_WINDOW_LENGTH)
            begin
                mode_next   = rad_pkg::MODE_MISSING;
                acc_next    = '0;
                above_next  = '0;
                below_next  = '0;
                zero_next   = '0;
                fill_next   = '0;
                active_next = '0;
                pos_next    = '0;
            end
        end
        else
        begin
            if (cmd.take_sample)
            begin
                acc_next = frame_end ? '0 : peak_cur;
            end

            if (cmd.update)
            begin
                seen_next   = seen_reg + 1'b1;
                fill_next   = win_full ? fill_reg : fill_reg + 1'b1;
                active_next = active_dec + FW'(flag);
                pos_next    = (pos_inc == w_eff) ? '0 : pos_inc[PW-1:0];
                zero_next   = zero_upd;
                above_next  = above_upd;
                below_next  = below_upd;

                if (zero_upd >= hg_cnt)
                begin
                    mode_next  = rad_pkg::MODE_MISSING;
                    above_next = '0;
                    below_next = '0;
                end
                else if (mode_reg != rad_pkg::MODE_ACTIVE)
                begin
                    if (mode_reg == rad_pkg::MODE_MISSING && frame_peak_reg != '0)
                    begin
                        mode_next = rad_pkg::MODE_IDLE;
                    end
                    if (above_upd >= st_cnt)
                    begin
                        mode_next    = rad_pkg::MODE_ACTIVE;
                        entered_next = entered_reg + 1'b1;
                        below_next   = '0;
                    end
                end
                else if (below_upd >= hg_cnt)
                begin
                    mode_next   = rad_pkg::MODE_IDLE;
                    exited_next = exited_reg + 1'b1;
                    above_next  = '0;
                end
            end
        end
    end

    // Hold configuration and activity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_thr_reg <= rad_pkg::ENTER_THRESHOLD_RST;
            exit_thr_reg  <= rad_pkg::EXIT_THRESHOLD_RST;
            stable_reg    <= rad_pkg::STABLE_COUNT_RST;
            hang_reg      <= rad_pkg::HANGOVER_COUNT_RST;
            win_len_reg   <= rad_pkg::WINDOW_LENGTH_RST;
            mode_reg      <= rad_pkg::MODE_MISSING;
            acc_reg       <= '0;
            above_reg     <= '0;
            below_reg     <= '0;
            zero_reg      <= '0;
            fill_reg      <= '0;
            active_reg    <= '0;
            pos_reg       <= '0;
            seen_reg      <= '0;
            entered_reg   <= '0;
            exited_reg    <= '0;
        end
        else
        begin
            enter_thr_reg <= enter_thr_next;
            exit_thr_reg  <= exit_thr_next;
            stable_reg    <= stable_next;
            hang_reg      <= hang_next;
            win_len_reg   <= win_len_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            above_reg     <= above_next;
            below_reg     <= below_next;
            zero_reg      <= zero_next;
            fill_reg      <= fill_next;
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            entered_reg   <= entered_next;
            exited_reg    <= exited_next;
        end
    end

    // Capture the finished frame peak
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample && frame_end)
        begin
            frame_peak_reg <= peak_cur;
        end
    end

    // Activity flag memory: read at the write position, write on frame update
    always_ff @(posedge clk)
    begin
        flag_rd_reg <= flag_mem[pos_eff];
        if (cmd.update && !cfg_write)
        begin
            flag_mem[pos_eff] <= flag;
        end
    end

    // Ratio of active frames in Q15
    rad_divider #(
        .FW (FW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .active   (active_reg),
        .fill     (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.ref_mode             <= mode_reg;
            result_reg.frame_peak           <= frame_peak_reg;
            result_reg.above_streak         <= above_reg;
            result_reg.below_streak         <= below_reg;
            result_reg.zero_streak          <= zero_reg;
            result_reg.active_ratio_q15     <= quotient;
            result_reg.frames_seen          <= seen_reg;
            result_reg.entered_active_count <= entered_reg;
            result_reg.exited_active_count  <= exited_reg;
        end
    end

    assign result = result_reg;

endmodule

// File: hdl/reference_activity_detector.sv
// Reference activity detector: a frame peak level detector with hysteresis.
// Top level; depends on rad_pkg, rad_if, rad_ctrl and rad_datapath.

// A sample that does not end a frame is taken while the controller stays idle.
// A sample with frame_end set holds the sample channel's ready low after its
// accept until the next accept, while the block runs capture, frame update,
// divider load, the 15 steps of the bit-serial ratio divider, the registered
// done flag of the divider reaching the controller and the load of the result
// register, which also waits while an earlier result is still pending.
// Samples keep flowing in while a finished result waits to be taken.
// Register writes are taken at any time through the configuration channel,
// which is always ready; a write to a valid index clears the activity state.
module reference_activity_detector #(
    parameter int WINDOW_MAX = rad_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    rad_sample_if.sink      samples,
    rad_result_if.source    results,
    rad_cfg_if.sink         cfg
);

    rad_pkg::cmd_t    cmd;
    rad_pkg::status_t status;
    rad_pkg::result_t result;
    logic             in_ready;
    logic             out_valid;
    logic             cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    rad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .in_frame_end (samples.frame_end),
        .out_ready    (results.ready),
        .status       (status),
        .cmd          (cmd),
        .in_ready     (in_ready),
        .out_valid    (out_valid)
    );

    rad_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .ref_sample (samples.ref_sample),
        .frame_end  (samples.frame_end),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .result     (result)
    );

    // Drive the channels
    assign samples.ready                = in_ready;
    assign results.valid                = out_valid;
    assign results.ref_mode             = result.ref_mode;
    assign results.frame_peak           = result.frame_peak;
    assign results.above_streak         = result.above_streak;
    assign results.below_streak         = result.below_streak;
    assign results.zero_streak          = result.zero_streak;
    assign results.active_ratio_q15     = result.active_ratio_q15;
    assign results.frames_seen          = result.frames_seen;
    assign results.entered_active_count = result.entered_active_count;
    assign results.exited_active_count  = result.exited_active_count;

    // A frame update follows directly on the word that ended the frame
    a_update_after_frame_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.update |-> $past(samples.valid && samples.ready && samples.frame_end)
    ) else $error("frame update without a frame-ending word");

    // No input is taken while the divider's done flag is raised
    a_busy_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.div_done |-> !samples.ready
    ) else $error("sample channel ready during division");

    // A loaded result is presented on the next cycle
    a_result_presented: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> results.valid
    ) else $error("loaded result not presented");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the reference activity detector: drives sample
// words and register writes, predicts each frame report and checks the result
// channel. Depends on rad_pkg, rad_if and reference_activity_detector.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_SAMPLES = 430;
    localparam int HOLD_SAMPLES  = 80;
    localparam int PCM_MIN_MAG   = 32768;

    typedef enum int {
        FRAME_SILENT,
        FRAME_QUIET,
        FRAME_MID,
        FRAME_LOUD,
        FRAME_ANY
    } frame_kind_t;

    logic clk;
    logic rst_n;

    rad_sample_if samples ();
    rad_result_if results ();
    rad_cfg_if    cfg ();

    reference_activity_detector #(
        .WINDOW_MAX (rad_pkg::WINDOW_MAX_DEFAULT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    // Predicted register file
    logic [rad_pkg::THR_W-1:0]  enter_thr;
    logic [rad_pkg::THR_W-1:0]  exit_thr;
    logic [rad_pkg::HOLD_W-1:0] stable_need;
    logic [rad_pkg::HOLD_W-1:0] hang_need;
    logic [rad_pkg::WLEN_W-1:0] win_len;

    // Predicted detector state
    rad_pkg::mode_t              mode_now;
    logic [rad_pkg::PEAK_W-1:0]  peak_run;
    int unsigned                 above_run;
    int unsigned                 below_run;
    int unsigned                 zero_run;
    bit                          active_flag [rad_pkg::WINDOW_MAX_DEFAULT];
    int unsigned                 win_fill;
    int unsigned                 win_active;
    int unsigned                 win_pos;
    logic [rad_pkg::COUNT_W-1:0] seen_total;
    logic [rad_pkg::COUNT_W-1:0] entered_total;
    logic [rad_pkg::COUNT_W-1:0] exited_total;

    rad_pkg::result_t frame_reports [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    logic        results_held   = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned writes_done    = 0;
    int unsigned reports_checked = 0;
    int unsigned error_count    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Drop the activity state, keep the frame counters
    task automatic clear_activity_model();
        mode_now   = rad_pkg::MODE_MISSING;
        peak_run   = '0;
        above_run  = 0;
        below_run  = 0;
        zero_run   = 0;
        foreach (active_flag[i]) active_flag[i] = 1'b0;
        win_fill   = 0;
        win_active = 0;
        win_pos    = 0;
    endtask

    task automatic model_reg_write(input logic [rad_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [rad_pkg::CFG_DATA_W-1:0] value);
        bit hit;
        hit = 1'b1;
        case (idx)
            rad_pkg::REG_ENTER_THRESHOLD: enter_thr   = value[rad_pkg::THR_W-1:0];
            rad_pkg::REG_EXIT_THRESHOLD:  exit_thr    = value[rad_pkg::THR_W-1:0];
            rad_pkg::REG_STABLE_COUNT:    stable_need = value[rad_pkg::HOLD_W-1:0];
            rad_pkg::REG_HANGOVER_COUNT:  hang_need   = value[rad_pkg::HOLD_W-1:0];
            rad_pkg::REG_WINDOW_LENGTH:   win_len     = value[rad_pkg::WLEN_W-1:0];
            default:                      hit = 1'b0;
        endcase
        if (hit)
            clear_activity_model();
    endtask

    // Track the frame peak; at frame end compute the expected frame report
    task automatic predict_frame_report(input logic signed [rad_pkg::SAMPLE_W-1:0] s,
                                        input bit fe);
        int               mag;
        int unsigned      peak;
        int unsigned      ex;
        int unsigned      en;
        int unsigned      st;
        int unsigned      hg;
        int unsigned      w;
        int unsigned      pos;
        rad_pkg::result_t rep;

        mag = s;
        if (mag < 0)
            mag = -mag;
        if (mag > int'(rad_pkg::Q15_ONE))
            mag = int'(rad_pkg::Q15_ONE);
        if (mag > peak_run)
            peak_run = mag[rad_pkg::PEAK_W-1:0];
        if (!fe)
            return;

        peak     = 32'(peak_run);
        peak_run = '0;
        ex = 32'(exit_thr);
        en = 32'((enter_thr < exit_thr) ? exit_thr : enter_thr);
        st = (stable_need == 0) ? 1 : stable_need;
        hg = (hang_need == 0) ? 1 : hang_need;
        seen_total++;

        // Advance the activity window
        w = (win_len == 0) ? 1 : win_len;
        if (w > rad_pkg::WINDOW_MAX_DEFAULT)
            w = rad_pkg::WINDOW_MAX_DEFAULT;
        pos = (win_pos >= w) ? 0 : win_pos;
        if (win_fill < w)
            win_fill++;
        else
            win_active -= 32'(active_flag[pos]);
        active_flag[pos] = (peak >= ex);
        win_active += (peak >= ex) ? 1 : 0;
        win_pos = (pos + 1) % w;

        // Saturating streaks
        zero_run  = (peak == 0) ?
                    ((zero_run < rad_pkg::STREAK_MAX) ? zero_run + 1 : zero_run) : 0;
        above_run = (peak >= en) ?
                    ((above_run < rad_pkg::STREAK_MAX) ? above_run + 1 : above_run) : 0;
        below_run = (peak < ex) ?
                    ((below_run < rad_pkg::STREAK_MAX) ? below_run + 1 : below_run) : 0;

        // Mode update with hysteresis
        if (zero_run >= hg)
        begin
            mode_now  = rad_pkg::MODE_MISSING;
            above_run = 0;
            below_run = 0;
        end
        else
        begin
            if (mode_now == rad_pkg::MODE_MISSING && peak > 0)
                mode_now = rad_pkg::MODE_IDLE;
            if (mode_now != rad_pkg::MODE_ACTIVE)
            begin
                if (above_run >= st)
                begin
                    mode_now = rad_pkg::MODE_ACTIVE;
                    entered_total++;
                    below_run = 0;
                end
            end
            else if (below_run >= hg)
            begin
                mode_now = rad_pkg::MODE_IDLE;
                exited_total++;
                above_run = 0;
            end
        end

        rep.ref_mode             = mode_now;
        rep.frame_peak           = peak[rad_pkg::PEAK_W-1:0];
        rep.above_streak         = above_run[rad_pkg::STREAK_W-1:0];
        rep.below_streak         = below_run[rad_pkg::STREAK_W-1:0];
        rep.zero_streak          = zero_run[rad_pkg::STREAK_W-1:0];
        rep.active_ratio_q15     = (win_fill == 0) ? '0 :
                                   rad_pkg::Q15_W'((win_active * 32'(rad_pkg::Q15_ONE))
                                                   / win_fill);
        rep.frames_seen          = seen_total;
        rep.entered_active_count = entered_total;
        rep.exited_active_count  = exited_total;
        frame_reports.push_back(rep);
    endtask

    // Offer one sample word, idling at random first
    task automatic send_sample(input logic signed [rad_pkg::SAMPLE_W-1:0] s, input bit fe);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid      <= 1'b1;
        samples.ref_sample <= s;
        samples.frame_end  <= fe;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        predict_frame_report(s, fe);
        samples_sent++;
    endtask

    // Hold the sender until every report is in, then let the block settle
    task automatic drain_reports();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (frame_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rad_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        model_reg_write(idx, value);
        writes_done++;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [rad_pkg::CFG_DATA_W-1:0] en,
                              input logic [rad_pkg::CFG_DATA_W-1:0] ex,
                              input logic [rad_pkg::CFG_DATA_W-1:0] st,
                              input logic [rad_pkg::CFG_DATA_W-1:0] hg,
                              input logic [rad_pkg::CFG_DATA_W-1:0] wl);
        drain_reports();
        write_reg(rad_pkg::REG_ENTER_THRESHOLD, en);
        write_reg(rad_pkg::REG_EXIT_THRESHOLD, ex);
        write_reg(rad_pkg::REG_STABLE_COUNT, st);
        write_reg(rad_pkg::REG_HANGOVER_COUNT, hg);
        write_reg(rad_pkg::REG_WINDOW_LENGTH, wl);
    endtask

    function automatic logic signed [rad_pkg::SAMPLE_W-1:0] signed_sample(
        input int unsigned mag);
        int v;
        if (mag >= PCM_MIN_MAG)
            return {1'b1, {(rad_pkg::SAMPLE_W-1){1'b0}}};
        v = ($urandom_range(1) == 1) ? -int'(mag) : int'(mag);
        return v[rad_pkg::SAMPLE_W-1:0];
    endfunction

    // Send one frame whose peak falls in the band named by kind; FRAME_ANY sends random words
    task automatic send_frame(input frame_kind_t kind, input int unsigned len);
        int unsigned lead;
        int unsigned ex;
        int unsigned en;
        int unsigned mag;
        logic signed [rad_pkg::SAMPLE_W-1:0] s;

        ex   = 32'(exit_thr);
        en   = 32'((enter_thr < exit_thr) ? exit_thr : enter_thr);
        lead = $urandom_range(len - 1, 0);
        for (int i = 0; i < len; i++)
        begin
            mag = 0;
            case (kind)
                FRAME_QUIET:
                    if (ex != 0)
                        mag = (i == lead && $urandom_range(3) == 0) ? ex - 1
                                                                    : $urandom_range(ex - 1, 0);
                FRAME_MID:
                    if (i == lead)
                        mag = (en > ex) ? $urandom_range(en - 1, ex) : ex;
                    else if (ex != 0)
                        mag = $urandom_range(ex - 1, 0);
                FRAME_LOUD:
                    if (i == lead)
                        mag = ($urandom_range(3) == 0) ? en : $urandom_range(PCM_MIN_MAG, en);
                    else
                        mag = $urandom_range(PCM_MIN_MAG, 0);
                default:
                    mag = 0;
            endcase
            if (kind == FRAME_ANY)
                s = rad_pkg::SAMPLE_W'($urandom);
            else
                s = signed_sample(mag);
            send_sample(s, i == len - 1);
        end
    endtask

    // Runs of frames that push the mode machine through its states, with noise
    task automatic run_frame_sequences(input int unsigned target);
        int unsigned start;
        int unsigned run_cap;
        int unsigned pick;
        int unsigned len;
        frame_kind_t kind;

        start = samples_sent;
        while (samples_sent - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                kind = FRAME_SILENT;
            else if (pick < 40)
                kind = FRAME_QUIET;
            else if (pick < 55)
                kind = FRAME_MID;
            else if (pick < 85)
                kind = FRAME_LOUD;
            else
                kind = FRAME_ANY;

            if (kind == FRAME_SILENT || kind == FRAME_QUIET)
                run_cap = ((hang_need == 0) ? 1 : hang_need) + 1;
            else if (kind == FRAME_LOUD)
                run_cap = ((stable_need == 0) ? 1 : stable_need) + 2;
            else
                run_cap = 4;
            if (run_cap > 12)
                run_cap = 12;

            repeat ($urandom_range(run_cap, 1))
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
                send_frame(kind, len);
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_report();
        rad_pkg::result_t want;
        if (frame_reports.size() == 0)
        begin
            $display("%0t: unexpected frame report, frames_seen %0d", $time, results.frames_seen);
            error_count++;
            return;
        end
        want = frame_reports.pop_front();
        check_field("ref_mode", want.ref_mode, results.ref_mode);
        check_field("frame_peak", want.frame_peak, results.frame_peak);
        check_field("above_streak", want.above_streak, results.above_streak);
        check_field("below_streak", want.below_streak, results.below_streak);
        check_field("zero_streak", want.zero_streak, results.zero_streak);
        check_field("active_ratio_q15", want.active_ratio_q15, results.active_ratio_q15);
        check_field("frames_seen", want.frames_seen, results.frames_seen);
        check_field("entered_active_count", want.entered_active_count,
                    results.entered_active_count);
        check_field("exited_active_count", want.exited_active_count,
                    results.exited_active_count);
        reports_checked++;
    endtask

    // Result side: stall at random, check every accepted word
    always @(posedge clk)
    begin
        results.ready <= !results_held && ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && results.valid && results.ready)
            check_report();
    end

    // Long receiver hold-off, counted here
    initial
    begin
        int unsigned span;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                span = hold_request;
                hold_request = 0;
                results_held <= 1'b1;
                repeat (span) @(posedge clk);
                results_held <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, frame_reports.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Signal extremes and the walk from missing to active and back to missing
    task automatic test_extremes();
        send_sample(-32768, 1'b1);
        send_sample(32767, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(-32767, 1'b1);
        send_sample(16'shAAAA, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(63, 1'b1);
        send_sample(64, 1'b1);
        send_sample(-127, 1'b0);
        send_sample(128, 1'b1);
        repeat (8) send_sample(0, 1'b1);
    endtask

    // Ignored indexes, a cleared frame in progress, zero/all-ones, enter < exit
    task automatic test_register_edges();
        int idx;

        // Unused indexes must not clear the partial frame
        send_sample(300, 1'b0);
        drain_reports();
        for (idx = rad_pkg::REG_WINDOW_LENGTH + 1; idx < (1 << rad_pkg::CFG_IDX_W); idx++)
            write_reg(idx[rad_pkg::CFG_IDX_W-1:0], 16'hFFFF);
        send_sample(-7, 1'b1);

        // A real write drops the frame in progress
        send_sample(20000, 1'b0);
        drain_reports();
        write_reg(rad_pkg::REG_STABLE_COUNT, 16'd1);
        send_sample(5, 1'b1);

        // All zero: thresholds at zero, counts and window taken as one
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(0, 1'b1);
        send_sample(1, 1'b1);
        send_sample(0, 1'b1);

        // All ones: thresholds mask to full scale, window clamps
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(-32768, 1'b1);
        send_sample(32766, 1'b1);

        // Enter threshold below exit threshold
        set_config(16'd100, 16'd1000, 16'd2, 16'd2, 16'd17);
        send_sample(500, 1'b1);
        send_sample(1000, 1'b1);
        send_sample(-1000, 1'b1);
        send_sample(999, 1'b1);
        send_sample(5, 1'b1);
    endtask

    task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [rad_pkg::CFG_DATA_W-1:0] en,
                                     input logic [rad_pkg::CFG_DATA_W-1:0] ex,
                                     input logic [rad_pkg::CFG_DATA_W-1:0] st,
                                     input logic [rad_pkg::CFG_DATA_W-1:0] hg,
                                     input logic [rad_pkg::CFG_DATA_W-1:0] wl);
        set_config(en, ex, st, hg, wl);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        run_frame_sequences(PHASE_SAMPLES);
        drain_reports();
    endtask

    // Block the result side so the detector backs up into its input
    task automatic test_receiver_hold();
        set_config(16'd150, 16'd80, 16'd2, 16'd3, 16'd6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        run_frame_sequences(HOLD_SAMPLES);
        drain_reports();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        samples.valid      <= 1'b0;
        samples.ref_sample <= '0;
        samples.frame_end  <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.index          <= '0;
        cfg.data           <= '0;

        enter_thr     = rad_pkg::ENTER_THRESHOLD_RST;
        exit_thr      = rad_pkg::EXIT_THRESHOLD_RST;
        stable_need   = rad_pkg::STABLE_COUNT_RST;
        hang_need     = rad_pkg::HANGOVER_COUNT_RST;
        win_len       = rad_pkg::WINDOW_LENGTH_RST;
        seen_total    = '0;
        entered_total = '0;
        exited_total  = '0;
        clear_activity_model();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_register_edges();
        test_random_phase(21, 84, 16'd200, 16'd100, 16'd2, 16'd3, 16'd1);
        test_random_phase(84, 21, 16'd3000, 16'd2000, 16'd5, 16'd4, 16'd16);
        test_random_phase(0, 0, 16'd50, 16'd300, 16'd4, 16'd6, 16'd31);
        test_receiver_hold();

        if (frame_reports.size() != 0)
        begin
            $display("%0t: %0d frame reports never arrived", $time, frame_reports.size());
            error_count++;
        end
        $display("tb_top: %0d samples, %0d register writes, %0d frame reports checked",
                 samples_sent, writes_done, reports_checked);
        $display("tb_top: reference went active %0d times and back to idle %0d times",
                 entered_total, exited_total);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/rad_pkg.sv
hdl/rad_if.sv
hdl/rad_divider.sv
hdl/rad_ctrl.sv
hdl/rad_datapath.sv
hdl/reference_activity_detector.sv
test/tb_top.sv
